@@ design/tka_pkg.sv @@
`default_nettype none

package tka_pkg;

   localparam int ScoreW = 32;
   localparam int CsrW   = 5;

   typedef logic signed [ScoreW-1:0] score_type;

   // Control that moves from the top level into the ranking list.
   typedef struct packed {
      logic accept;
      logic row_end;
   } list_ctrl_type;

endpackage

`default_nettype wire

@@ design/tka_list.sv @@
`default_nettype none

module tka_list
   import tka_pkg::*;
#(
   parameter int KEEP_MAX = 16,
   parameter int ROW_MAX  = 4096,
   localparam int PosW    = $clog2(ROW_MAX),
   localparam int CountW  = $clog2(KEEP_MAX + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire list_ctrl_type   ctrl,
   input  wire score_type       score,
   output logic     [PosW-1:0]  snap_pos [KEEP_MAX],
   output logic     [CountW-1:0] snap_fill
);

   localparam logic [PosW-1:0]   PosLast  = PosW'(ROW_MAX - 1);
   localparam logic [CountW-1:0] CountMax = CountW'(KEEP_MAX);

   score_type          best_score_ff [KEEP_MAX];
   score_type          best_score_in [KEEP_MAX];
   logic [PosW-1:0]    best_pos_ff   [KEEP_MAX];
   logic [CountW-1:0]  fill_ff;
   logic [CountW-1:0]  fill_in;
   logic [PosW-1:0]    count_ff;
   logic [PosW-1:0]    count_in;
   logic [KEEP_MAX-1:0] above;

   // Kept entries form a descending run, so the entries above the new score are a prefix.
   // A new score ties below nothing: the later position ranks first.
   always_comb begin
      for (int i = 0; i < KEEP_MAX; i++) begin
         above[i] = (CountW'(i) < fill_ff) && (best_score_ff[i] > score);
      end
      for (int i = 0; i < KEEP_MAX; i++) begin
         if (above[i]) begin
            best_score_in[i] = best_score_ff[i];
            snap_pos[i]      = best_pos_ff[i];
         end else if (i == 0) begin
            best_score_in[i] = score;
            snap_pos[i]      = count_ff;
         end else if (above[i-1]) begin
            best_score_in[i] = score;
            snap_pos[i]      = count_ff;
         end else begin
            best_score_in[i] = best_score_ff[i-1];
            snap_pos[i]      = best_pos_ff[i-1];
         end
      end
      fill_in  = (fill_ff < CountMax) ? fill_ff + 1'b1 : fill_ff;
      count_in = (count_ff < PosLast) ? count_ff + 1'b1 : count_ff;
   end

   assign snap_fill = fill_in;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         for (int i = 0; i < KEEP_MAX; i++) begin
            best_score_ff[i] <= best_score_in[i];
            best_pos_ff[i]   <= snap_pos[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (ctrl.accept) begin
         // clear for the next row once the last element is in
         if (ctrl.row_end) begin
            fill_ff  <= '0;
            count_ff <= '0;
         end else begin
            fill_ff  <= fill_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/top_k_argsort.sv @@
`default_nettype none

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_score (s32 Q16.16), req_row_end
// rsp      out        rsp_valid/stall    rsp_position, rsp_run_end
// csr      in         csr_valid/ready    csr_keep_count (5 bits)
//
// One element is ranked per cycle while req_stall is low: the insert into the sorted
// list compares the score against all kept entries combinationally.
// A row end loads the ranked positions into a drain shift register, which emits one
// position per cycle while rsp_stall is low from the next cycle on, so a row yields
// min(keep_count, row length) results, keep_count taken as 1 at 0, KEEP_MAX above it.
// A row-end element stalls until the cycle of the previous row's last position.
// Reset is synchronous; it empties the list and the drain and sets keep_count to 1.
module top_k_argsort
   import tka_pkg::*;
#(
   parameter int KEEP_MAX = 16,
   parameter int ROW_MAX  = 4096,
   localparam int PosW    = $clog2(ROW_MAX)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ScoreW-1:0] req_score,
   input  wire logic              req_row_end,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PosW-1:0]   rsp_position,
   output logic                   rsp_run_end,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CsrW-1:0]   csr_keep_count
);

   localparam int CountW = $clog2(KEEP_MAX + 1);
   localparam logic [CountW-1:0] CountMax = CountW'(KEEP_MAX);

   logic [CsrW-1:0]    keep_count_ff;
   logic [CountW-1:0]  keep_eff;
   logic [CountW-1:0]  emit_count;
   list_ctrl_type      ctrl;
   logic [PosW-1:0]    snap_pos [KEEP_MAX];
   logic [CountW-1:0]  snap_fill;
   logic [PosW-1:0]    drain_pos_ff [KEEP_MAX];
   logic [CountW-1:0]  remain_ff;
   logic               busy;
   logic               pop;
   logic               last_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= CsrW'(1);
      end else if (csr_valid && csr_ready) begin
         keep_count_ff <= csr_keep_count;
      end
   end

   // Zero acts as one; anything past the list depth acts as the depth.
   always_comb begin
      priority if (keep_count_ff == '0) begin
         keep_eff = CountW'(1);
      end else if (32'(keep_count_ff) > 32'(KEEP_MAX)) begin
         keep_eff = CountMax;
      end else begin
         keep_eff = CountW'(keep_count_ff);
      end
      emit_count = (keep_eff < snap_fill) ? keep_eff : snap_fill;
   end

   assign busy      = (remain_ff != '0);
   assign pop       = busy && !rsp_stall;
   assign last_pop  = pop && (remain_ff == CountW'(1));
   assign req_stall = req_row_end && busy && !last_pop;

   assign ctrl.accept  = req_valid && !req_stall;
   assign ctrl.row_end = req_row_end;

   tka_list #(
      .KEEP_MAX (KEEP_MAX),
      .ROW_MAX  (ROW_MAX)
   ) u_list (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .score     (score_type'(req_score)),
      .snap_pos  (snap_pos),
      .snap_fill (snap_fill)
   );

   always_ff @(posedge clock) begin
      if (ctrl.accept && ctrl.row_end) begin
         drain_pos_ff <= snap_pos;
      end else if (pop) begin
         // advance the drain by one position
         for (int i = 0; i < KEEP_MAX - 1; i++) begin
            drain_pos_ff[i] <= drain_pos_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else if (ctrl.accept && ctrl.row_end) begin
         remain_ff <= emit_count;
      end else if (pop) begin
         remain_ff <= remain_ff - 1'b1;
      end
   end

   assign rsp_valid    = busy;
   assign rsp_position = drain_pos_ff[0];
   assign rsp_run_end  = (remain_ff == CountW'(1));

endmodule

`default_nettype wire

@@ design/tka_checker.sv @@
`default_nettype none

module tka_checker
   import tka_pkg::*;
#(
   parameter int ROW_MAX = 4096,
   localparam int PosW   = $clog2(ROW_MAX)
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              req_row_end,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [PosW-1:0]   rsp_position,
   input wire logic              rsp_run_end
);

   // A held result item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) && $stable(rsp_run_end))
      else $error("rsp item changed while stalled");

   // Reset empties the drain.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // Every accepted row end produces results in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_row_end |=> rsp_valid)
      else $error("row end without results");

   // Elements inside a row are never held back.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_row_end |-> !req_stall)
      else $error("mid-row item stalled");

endmodule

bind top_k_argsort tka_checker #(
   .ROW_MAX (ROW_MAX)
) u_tka_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_row_end  (req_row_end),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_position (rsp_position),
   .rsp_run_end  (rsp_run_end)
);

`default_nettype wire

@@ tb/sv/top_k_argsort_checker.sv @@
`timescale 1ns / 1ps

module top_k_argsort_checker
   import tka_pkg::*;
#(
   parameter int KeepMax = 16,
   parameter int RowMax  = 4096,
   localparam int PosW   = $clog2(RowMax)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [ScoreW-1:0] req_score,
   input  wire logic              req_row_end,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [PosW-1:0]   rsp_position,
   input  wire logic              rsp_run_end,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [CsrW-1:0]   csr_keep_count,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [PosW-1:0] position;
      logic            run_end;
   } ranked_pos_type;

   score_type       kept_score [KeepMax];
   logic [PosW-1:0] kept_pos [KeepMax];
   int              kept_used;
   logic [PosW-1:0] next_pos;
   logic [CsrW-1:0] keep_setting;
   ranked_pos_type  due_positions [$];

   // Stop at the first kept score that is not higher: the newer element wins ties.
   function automatic void rank_element(score_type s);
      int slot;
      int last;
      int i;
      slot = 0;
      while (slot < kept_used && kept_score[slot] > s) slot++;
      if (slot < KeepMax) begin
         last = (kept_used < KeepMax) ? kept_used : KeepMax - 1;
         for (i = last; i > slot; i--) begin
            kept_score[i] = kept_score[i-1];
            kept_pos[i]   = kept_pos[i-1];
         end
         kept_score[slot] = s;
         kept_pos[slot]   = next_pos;
         if (kept_used < KeepMax) kept_used++;
      end
   endfunction

   function automatic void close_row();
      int n;
      int i;
      ranked_pos_type r;
      n = keep_setting;
      if (n == 0) n = 1;
      if (n > KeepMax) n = KeepMax;
      if (n > kept_used) n = kept_used;
      for (i = 0; i < n; i++) begin
         r.position = kept_pos[i];
         r.run_end  = (i == n - 1);
         due_positions.insert(due_positions.size(), r);
      end
      kept_used = 0;
      next_pos  = '0;
   endfunction

   always @(posedge clock) begin : watch
      ranked_pos_type seen;
      if (reset) begin
         kept_used    = 0;
         next_pos     = '0;
         keep_setting = 5'd1;
         due_positions.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_positions.size() == 0) begin
               $error("rsp: item with no position due (position %0d)", rsp_position);
               fail_count++;
            end else begin
               seen = due_positions.pop_front();
               if (rsp_position !== seen.position) begin
                  $error("position: expected %0d, got %0d", seen.position, rsp_position);
                  fail_count++;
               end
               if (rsp_run_end !== seen.run_end) begin
                  $error("run_end: expected %0b, got %0b", seen.run_end, rsp_run_end);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            rank_element(req_score);
            // saturate on overlong rows
            if (next_pos != RowMax - 1) next_pos++;
            if (req_row_end) close_row();
         end
         // the new keep count takes effect after this edge
         if (csr_valid && csr_ready) keep_setting = csr_keep_count;
      end
      pending = due_positions.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import tka_pkg::*;

   localparam int KeepMax = 16;
   localparam int RowMax  = 4096;
   localparam int PosW    = $clog2(RowMax);

   localparam score_type ScoreHi = score_type'(32'h7FFF_FFFF);
   localparam score_type ScoreLo = score_type'(32'h8000_0000);

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic [ScoreW-1:0] req_score = '0;
   logic              req_row_end = 1'b0;
   logic              rsp_stall = 1'b0;
   logic              csr_valid = 1'b0;
   logic [CsrW-1:0]   csr_keep_count = 5'd1;
   wire logic         req_stall;
   wire logic         rsp_valid;
   wire logic [PosW-1:0] rsp_position;
   wire logic         rsp_run_end;
   wire logic         csr_ready;

   int fail_count;
   int pending;
   bit quiet = 1'b0;
   int stall_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   top_k_argsort #(
      .KEEP_MAX (KeepMax),
      .ROW_MAX  (RowMax)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_score      (req_score),
      .req_row_end    (req_row_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_run_end    (rsp_run_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_keep_count (csr_keep_count)
   );

   top_k_argsort_checker #(
      .KeepMax (KeepMax),
      .RowMax  (RowMax)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_score      (req_score),
      .req_row_end    (req_row_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_run_end    (rsp_run_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_keep_count (csr_keep_count),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // Receiver backpressure in random bursts.
   always @(negedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_score(input score_type s, input logic row_end);
      req_valid   <= 1'b1;
      req_score   <= s;
      req_row_end <= row_end;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic write_keep(input logic [CsrW-1:0] value);
      csr_valid      <= 1'b1;
      csr_keep_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every due position, then let the drain finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic score_type pick_score(int style);
      case (style)
         0: pick_score = score_type'($urandom);
         1: pick_score = score_type'($urandom_range(0, 7)) - 4;
         default: begin
            case ($urandom_range(0, 3))
               0: pick_score = ScoreHi;
               1: pick_score = ScoreLo;
               2: pick_score = '0;
               default: pick_score = -1;
            endcase
         end
      endcase
   endfunction

   task automatic random_row(output int length);
      int style;
      int i;
      length = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      style  = $urandom_range(0, 3);
      for (i = 0; i < length; i++)
         push_score(pick_score(style == 3 ? $urandom_range(0, 2) : style), i == length - 1);
   endtask

   initial begin : stimulus
      int sent;
      int length;
      int i;
      int p;
      logic [CsrW-1:0] keep_plan [6];
      keep_plan[0] = 5'd16;
      keep_plan[1] = 5'd1;
      keep_plan[2] = 5'd7;
      keep_plan[3] = 5'd17;
      keep_plan[4] = 5'd0;
      keep_plan[5] = 5'($urandom_range(0, 31));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // keep count from reset; equal scores go to the later element
      push_score(-5, 1'b0);
      push_score(7, 1'b0);
      push_score(7, 1'b1);
      settle();
      write_keep(5'd16);
      // short rows
      push_score(ScoreLo, 1'b1);
      push_score(ScoreHi, 1'b0);
      push_score(ScoreLo, 1'b0);
      push_score('0, 1'b0);
      push_score(-1, 1'b0);
      push_score(1, 1'b1);
      settle();
      write_keep(5'd0);
      push_score(3, 1'b0);
      push_score(9, 1'b0);
      push_score(-9, 1'b1);
      settle();
      write_keep(5'd31);
      for (i = 0; i < 12; i++) push_score(pick_score(1), i == 11);

      for (p = 0; p < 6; p++) begin
         settle();
         if (p == 5) quiet = 1'b1;
         write_keep(keep_plan[p]);
         sent = 0;
         while (sent < 24) begin
            random_row(length);
            sent += length;
         end
      end

      settle();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

@@ top_k_argsort.f @@
design/tka_pkg.sv
design/tka_list.sv
design/top_k_argsort.sv
design/tka_checker.sv
tb/sv/top_k_argsort_checker.sv
tb/sv/tb.sv
